[sv/bsm_pkg.sv]
// bsm_pkg: shared types and constants of the backing store map table
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

   // field widths fixed by the item format
   localparam int MODE_W = 2;
   localparam int PID_W  = 5;
   localparam int SI_W   = 3;
   localparam int BASE_W = 20;
   localparam int CNT_W  = 9;
   localparam int ADDR_W = 32;
   localparam int OFF_W  = 8;

   // request codes
   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_MAP    = 2'd2,
      MODE_LOOKUP = 2'd3
   } mode_type;

   // result status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // outcome of the window search
   typedef struct packed {
      logic             hit;
      logic [SI_W-1:0]  store;
      logic [OFF_W-1:0] offset;
   } match_type;

endpackage

`default_nettype wire

[sv/bsm_ram.sv]
// bsm_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bsm_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/bsm_match.sv]
// bsm_match: parallel window compare over all stores and lowest-index pick
`timescale 1ns / 1ps
`default_nettype none

module bsm_match #(
   parameter int STORES = 8,
   parameter int PAGE_W = 20
) (
   input  logic [STORES*bsm_pkg::BASE_W-1:0] base_row,
   input  logic [STORES-1:0]                 use_bit,
   input  logic [bsm_pkg::CNT_W-1:0]         pages [STORES],
   input  logic [PAGE_W-1:0]                 page,
   output bsm_pkg::match_type                result
);

   import bsm_pkg::*;

   // wide enough for the page number and for base plus count
   localparam int CMP_W = (PAGE_W > BASE_W + 1) ? PAGE_W : BASE_W + 1;

   logic [STORES-1:0] hit;
   logic [OFF_W-1:0]  offset [STORES];
   logic [CMP_W-1:0]  page_ext;

   assign page_ext = CMP_W'(page);

   // one window compare per store
   for (genvar s = 0; s < STORES; s++) begin : g_store
      logic [CMP_W-1:0] start;
      logic [CMP_W-1:0] stop;
      logic [CMP_W-1:0] diff;

      assign start     = CMP_W'(base_row[s*BASE_W +: BASE_W]);
      assign stop      = start + CMP_W'(pages[s]);
      assign diff      = page_ext - start;
      assign hit[s]    = use_bit[s] && (page_ext >= start) && (page_ext < stop);
      assign offset[s] = diff[OFF_W-1:0];
   end

   // lowest-numbered hit wins
   always_comb begin
      result = '0;
      for (int s = STORES - 1; s >= 0; s--) begin
         if (hit[s]) begin
            result.hit    = 1'b1;
            result.store  = SI_W'(s);
            result.offset = offset[s];
         end
      end
   end

endmodule

`default_nettype wire

[sv/backing_store_map_table_unit.sv]
// backing_store_map_table_unit: backing store table with allocate, free, map and lookup
// An accepted item is captured and enters execute; its result is registered once the
// output register is free, and only then is a new item taken. The base-page memory row
// (one row per process) is read at accept, then compared or written back for map.
// An item is accepted while an earlier result still waits in the output register.
// Reset clears mapped flags, page counts and process bits at once; the base-page
// memory is not cleared, since an entry is read only behind a process bit set by map.
`timescale 1ns / 1ps
`default_nettype none

module backing_store_map_table_unit #(
   parameter int STORES     = 8,
   parameter int PROCS      = 32,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [bsm_pkg::MODE_W-1:0] req_mode,
   input  logic [bsm_pkg::PID_W-1:0]  req_proc_id,
   input  logic [bsm_pkg::SI_W-1:0]   req_store_index,
   input  logic [bsm_pkg::BASE_W-1:0] req_base_page,
   input  logic [bsm_pkg::CNT_W-1:0]  req_page_count,
   input  logic [bsm_pkg::ADDR_W-1:0] req_virt_address,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_status,
   output logic [bsm_pkg::SI_W-1:0]   rsp_found_store,
   output logic [bsm_pkg::OFF_W-1:0]  rsp_page_offset
);

   import bsm_pkg::*;

   // PAGE_BYTES is a power of two: page number is a shift of the address
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
   localparam int SIDX_W     = (STORES > 1) ? $clog2(STORES) : 1;
   localparam int PIDX_W     = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int ROW_W      = STORES * BASE_W;

   // sequencer
   state_type state_ff, state_in;
   logic      accept;
   logic      out_free;
   logic      commit;

   // captured item
   mode_type            mode_ff;
   logic [PIDX_W-1:0]   pid_idx_ff;
   logic                pid_ok_ff;
   logic [SIDX_W-1:0]   si_idx_ff;
   logic                si_ok_ff;
   logic [BASE_W-1:0]   base_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [PAGE_W-1:0]   page_ff;

   logic [5:0]          pid_ext;
   logic [5:0]          si_ext;

   // store tables
   logic                mapped_ff [STORES];
   logic                mapped_in [STORES];
   logic [CNT_W-1:0]    pages_ff  [STORES];
   logic [CNT_W-1:0]    pages_in  [STORES];
   logic [PROCS-1:0]    pbits_ff  [STORES];
   logic [PROCS-1:0]    pbits_in  [STORES];

   // base-page memory
   logic [ROW_W-1:0]    rd_row;
   logic [ROW_W-1:0]    wr_row;
   logic                mem_wr_en;

   // search
   logic [STORES-1:0]   use_bit;
   match_type           match;
   logic                alloc_hit;
   logic [SI_W-1:0]     alloc_store;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [SI_W-1:0]     rsp_found_ff, rsp_found_in;
   logic [OFF_W-1:0]    rsp_offset_ff, rsp_offset_in;

   assign pid_ext  = 6'(req_proc_id);
   assign si_ext   = 6'(req_store_index);
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: commit    = out_free;
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the item and its range checks
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= mode_type'(req_mode);
         pid_idx_ff <= pid_ext[PIDX_W-1:0];
         pid_ok_ff  <= {27'b0, req_proc_id} < PROCS;
         si_idx_ff  <= si_ext[SIDX_W-1:0];
         si_ok_ff   <= {29'b0, req_store_index} < STORES;
         base_ff    <= req_base_page;
         cnt_ff     <= req_page_count;
         page_ff    <= req_virt_address[ADDR_W-1:PAGE_SHIFT];
      end
   end

   // one memory row per process, one base-page slice per store
   bsm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (PROCS)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (pid_idx_ff),
      .wr_data (wr_row),
      .rd_en   (accept),
      .rd_addr (pid_ext[PIDX_W-1:0]),
      .rd_data (rd_row)
   );

   // map rewrites the row with the store's slice replaced
   always_comb begin
      wr_row = rd_row;
      wr_row[si_idx_ff*BASE_W +: BASE_W] = base_ff;
   end

   assign mem_wr_en = commit && (mode_ff == MODE_MAP) && si_ok_ff && pid_ok_ff;

   // process bit of every store for the captured process
   always_comb begin
      for (int s = 0; s < STORES; s++) begin
         use_bit[s] = pbits_ff[s][pid_idx_ff];
      end
   end

   bsm_match #(
      .STORES (STORES),
      .PAGE_W (PAGE_W)
   ) u_match (
      .base_row (rd_row),
      .use_bit  (use_bit),
      .pages    (pages_ff),
      .page     (page_ff),
      .result   (match)
   );

   // lowest unmapped store
   always_comb begin
      alloc_hit   = 1'b0;
      alloc_store = '0;
      for (int s = STORES - 1; s >= 0; s--) begin
         if (!mapped_ff[s]) begin
            alloc_hit   = 1'b1;
            alloc_store = SI_W'(s);
         end
      end
   end

   // table updates for free and map
   always_comb begin
      for (int s = 0; s < STORES; s++) begin
         mapped_in[s] = mapped_ff[s];
         pages_in[s]  = pages_ff[s];
         pbits_in[s]  = pbits_ff[s];
      end
      if (commit && si_ok_ff) begin
         if (mode_ff == MODE_FREE) begin
            mapped_in[si_idx_ff] = 1'b0;
            pages_in[si_idx_ff]  = '0;
            pbits_in[si_idx_ff]  = '0;
         end else if (mode_ff == MODE_MAP && pid_ok_ff) begin
            mapped_in[si_idx_ff]            = 1'b1;
            pages_in[si_idx_ff]             = cnt_ff;
            pbits_in[si_idx_ff][pid_idx_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STORES; s++) begin
            mapped_ff[s] <= 1'b0;
            pages_ff[s]  <= '0;
            pbits_ff[s]  <= '0;
         end
      end else begin
         for (int s = 0; s < STORES; s++) begin
            mapped_ff[s] <= mapped_in[s];
            pages_ff[s]  <= pages_in[s];
            pbits_ff[s]  <= pbits_in[s];
         end
      end
   end

   // result of the item in flight
   always_comb begin
      rsp_status_in = STATUS_ERR;
      rsp_found_in  = '0;
      rsp_offset_in = '0;
      unique case (mode_ff)
         MODE_ALLOC: begin
            if (alloc_hit) begin
               rsp_status_in = STATUS_OK;
               rsp_found_in  = alloc_store;
            end
         end
         MODE_FREE: begin
            if (si_ok_ff) begin
               rsp_status_in = STATUS_OK;
            end
         end
         MODE_MAP: begin
            if (si_ok_ff && pid_ok_ff) begin
               rsp_status_in = STATUS_OK;
            end
         end
         MODE_LOOKUP: begin
            if (pid_ok_ff && match.hit) begin
               rsp_status_in = STATUS_OK;
               rsp_found_in  = match.store;
               rsp_offset_in = match.offset;
            end
         end
         default: rsp_status_in = STATUS_ERR;
      endcase
   end

   // output register valid
   always_comb begin
      priority if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_offset_ff <= rsp_offset_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_store = rsp_found_ff;
   assign rsp_page_offset = rsp_offset_ff;

`ifndef SYNTHESIS
   // an accepted item always moves to the execute state
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted item did not enter execute");

   // a new result appears only out of the execute state
   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result raised outside execute");

   // an error result carries no store and no offset
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_ERR)
         |-> (rsp_found_ff == '0 && rsp_offset_ff == '0))
      else $error("error result with nonzero fields");

   // a committed map leaves the store mapped
   a_map_marks: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> mapped_ff[$past(si_idx_ff)])
      else $error("mapped store not flagged");

   // a committed free leaves no process bits behind
   a_free_clears: assert property (@(posedge clock) disable iff (reset)
      (commit && mode_ff == MODE_FREE && si_ok_ff)
         |=> (pbits_ff[$past(si_idx_ff)] == '0 && !mapped_ff[$past(si_idx_ff)]))
      else $error("freed store still in use");
`endif

endmodule

`default_nettype wire
